>>> rtl/lkcb_pkg.sv
`default_nettype none

package lkcb_pkg;

    // Coordinate width of the column/row counters and box registers
    localparam int COORD_BITS = 12;
    // Largest frame size in pixels or lines
    localparam int SIZE_LIM = (COORD_BITS >= 12) ? 4096 : (1 << COORD_BITS);

    // Widths of the fixed fields
    localparam int BOX_BITS  = 12;
    localparam int SIZE_BITS = 13;
    localparam int IDX_BITS  = 3;
    localparam int OUT_BITS  = 88;

    // Register indexes of the configuration channel
    localparam logic [IDX_BITS-1:0] REG_FRAME_WIDTH     = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_FRAME_HEIGHT    = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_KEY_ENABLE      = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_KEY_THRESHOLD   = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_CONTRAST_ENABLE = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_CONTRAST_GAIN   = 3'd5;
    localparam logic [IDX_BITS-1:0] REG_CROP_MARGIN     = 3'd6;

    // Result kinds carried on tuser
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_BOX   = 1'b1;

    // ceil(2^28 / 1000): exact floor division by 1000 for sums up to 255000
    localparam logic [18:0] LUMA_RECIP = 19'd268436;
    localparam int          LUMA_SHIFT = 28;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_pixel;

    typedef struct packed {
        logic        key_en;
        logic [7:0]  key_thr;
        logic        con_en;
        logic [11:0] con_gain;
    } t_eng_cfg;

    // Last valid column or row index for a configured size
    function automatic logic [COORD_BITS-1:0] size_last(input logic [SIZE_BITS-1:0] size);
        if (size == '0) begin
            return '0;
        end else if (size > SIZE_BITS'(SIZE_LIM)) begin
            return COORD_BITS'(SIZE_LIM - 1);
        end else begin
            return COORD_BITS'(size - SIZE_BITS'(1));
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/lkcb_pix_eng.sv
`default_nettype none

module lkcb_pix_eng import lkcb_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_pixel   i_pixel,
    input  wire t_eng_cfg i_cfg,
    output logic          o_done,
    output t_pixel        o_pixel
);

    localparam logic [3:0] STEP_SUM   = 4'd3;
    localparam logic [3:0] STEP_LUM   = 4'd4;
    localparam logic [3:0] STEP_SETUP = 4'd5;
    localparam logic [3:0] STEP_LAST  = 4'd13;

    logic        r_busy;
    logic [3:0]  r_step;
    logic        r_done;
    logic [23:0] r_rgb;       // blue, green, red from the top down; rotates during stretch
    logic [7:0]  r_alpha_in;
    logic [17:0] r_sum;
    logic [7:0]  r_lum;
    logic        r_hit;
    logic [7:0]  r_rem;
    logic [7:0]  r_quo;       // numerator low byte shifts out, quotient bits shift in

    logic signed [8:0]  s_dv;
    logic signed [21:0] s_prod;
    logic [20:0]        s_round;
    logic [7:0]         n_chan;
    logic [17:0]        n_sum;
    logic [36:0]        n_lp;
    logic [7:0]         n_lum;
    logic [7:0]         n_x;
    logic [15:0]        n_num;
    logic [8:0]         n_trial;
    logic [9:0]         n_diff;
    logic               n_ge;

    // Stretch the channel in the low byte about 128, round half up, clamp
    always_comb begin
        s_dv    = $signed({1'b0, r_rgb[7:0]}) - 9'sd128;
        s_prod  = 22'(s_dv) * 22'($signed({1'b0, i_cfg.con_gain})) + 22'sd32768;
        s_round = s_prod[20:0] + 21'd128;
        if (!i_cfg.con_en) begin
            n_chan = r_rgb[7:0];
        end else if (s_prod[21]) begin
            n_chan = '0;
        end else if (|s_round[20:16]) begin
            n_chan = 8'hFF;
        end else begin
            n_chan = s_round[15:8];
        end
    end

    // Luma sum, then division by 1000 through the reciprocal
    always_comb begin
        n_sum = 18'(r_rgb[7:0]) * 18'd299 + 18'(r_rgb[15:8]) * 18'd587
              + 18'(r_rgb[23:16]) * 18'd114;
        n_lp  = 37'(r_sum) * 37'(LUMA_RECIP);
        n_lum = n_lp[LUMA_SHIFT+7:LUMA_SHIFT];
    end

    // Divider setup: numerator (threshold - luma) * 255, one quotient bit a step
    always_comb begin
        n_x     = i_cfg.key_thr - r_lum;
        n_num   = {n_x, 8'h00} - {8'h00, n_x};
        n_trial = {r_rem, r_quo[7]};
        n_diff  = {1'b0, n_trial} - {2'b00, i_cfg.key_thr};
        n_ge    = !n_diff[9];
    end

    // Step sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && !i_start && (r_step == STEP_LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == STEP_LAST) begin
                    r_busy <= 1'b0;
                end else begin
                    r_step <= r_step + 4'd1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rgb      <= {i_pixel.blue, i_pixel.green, i_pixel.red};
            r_alpha_in <= i_pixel.alpha;
        end else if (r_busy) begin
            if (r_step < STEP_SUM) begin
                r_rgb <= {n_chan, r_rgb[23:8]};
            end else if (r_step == STEP_SUM) begin
                r_sum <= n_sum;
            end else if (r_step == STEP_LUM) begin
                r_lum <= n_lum;
            end else if (r_step == STEP_SETUP) begin
                r_hit <= (i_cfg.key_thr > r_lum);
                r_rem <= n_num[15:8];
                r_quo <= n_num[7:0];
            end else begin
                r_rem <= n_ge ? n_diff[7:0] : n_trial[7:0];
                r_quo <= {r_quo[6:0], n_ge};
            end
        end
    end

    assign o_done        = r_done;
    assign o_pixel.red   = r_rgb[7:0];
    assign o_pixel.green = r_rgb[15:8];
    assign o_pixel.blue  = r_rgb[23:16];
    assign o_pixel.alpha = !i_cfg.key_en ? r_alpha_in : (r_hit ? r_quo : 8'h00);

endmodule

`default_nettype wire

>>> rtl/luma_key_with_contrast_and_bbox.sv
// Flow: an accepted pixel runs through the three-step shared stretch multiplier,
//   the luma steps and the eight-step bit-serial alpha divider; its result then enters
//   the output register once the output is free. A new pixel is accepted only after that,
//   and after the box report that follows the last pixel of a frame.
// Reset: synchronous, active low; configuration registers return to defaults, counters and box clear.
`default_nettype none

module luma_key_with_contrast_and_bbox import lkcb_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Pixel input
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [31:0]           s_axis_tdata,   // red, green, blue, alpha_in
    // Result output
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_BITS-1:0]        m_axis_tdata,   // red_out, green_out, blue_out,
                                                       // alpha_out, box_found, box_left,
                                                       // box_top, box_right, box_bottom, pad
    output logic                       m_axis_tuser,   // kind
    output logic                       m_axis_tlast,   // last
    // Configuration writes
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [IDX_BITS-1:0]   i_cfg_index,
    input  wire logic [SIZE_BITS-1:0]  i_cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_PIX  = 2'd2;
    localparam logic [1:0] ST_BOX  = 2'd3;
    localparam int CW = COORD_BITS + 1;

    logic [1:0]            r_state, n_state;

    logic [SIZE_BITS-1:0]  r_frame_width, r_frame_height;
    logic                  r_key_en, r_con_en;
    logic [7:0]            r_key_thr, r_margin;
    logic [11:0]           r_con_gain;

    logic [COORD_BITS-1:0] r_col, r_row, r_min_col, r_max_col, r_min_row, r_max_row;
    logic                  r_any;

    logic                  r_out_valid;
    logic [OUT_BITS-1:0]   r_out_data;
    logic                  r_out_user;
    logic                  r_out_last;

    logic                  s_accept;
    logic                  out_free;
    logic                  eng_done;
    t_pixel                in_pixel;
    t_pixel                eng_pixel;
    t_eng_cfg              eng_cfg;

    logic [COORD_BITS-1:0] w_last, h_last;
    logic                  opaque, line_end, frame_end;
    logic [CW-1:0]         b_margin, b_left, b_top, b_right, b_bottom;

    // Pixel engine
    assign in_pixel.red   = s_axis_tdata[7:0];
    assign in_pixel.green = s_axis_tdata[15:8];
    assign in_pixel.blue  = s_axis_tdata[23:16];
    assign in_pixel.alpha = s_axis_tdata[31:24];

    assign eng_cfg.key_en   = r_key_en;
    assign eng_cfg.key_thr  = r_key_thr;
    assign eng_cfg.con_en   = r_con_en;
    assign eng_cfg.con_gain = r_con_gain;

    lkcb_pix_eng u_eng (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_accept),
        .i_pixel (in_pixel),
        .i_cfg   (eng_cfg),
        .o_done  (eng_done),
        .o_pixel (eng_pixel)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 13'd460;
            r_frame_height <= 13'd160;
            r_key_en       <= 1'b1;
            r_key_thr      <= 8'd200;
            r_con_en       <= 1'b0;
            r_con_gain     <= 12'd768;
            r_margin       <= 8'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:     r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT:    r_frame_height <= i_cfg_data;
                REG_KEY_ENABLE:      r_key_en       <= i_cfg_data[0];
                REG_KEY_THRESHOLD:   r_key_thr      <= i_cfg_data[7:0];
                REG_CONTRAST_ENABLE: r_con_en       <= i_cfg_data[0];
                REG_CONTRAST_GAIN:   r_con_gain     <= i_cfg_data[11:0];
                REG_CROP_MARGIN:     r_margin       <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Frame position and box edges
    always_comb begin
        w_last    = size_last(r_frame_width);
        h_last    = size_last(r_frame_height);
        opaque    = (eng_pixel.alpha != 8'h00);
        line_end  = (r_col >= w_last);
        frame_end = line_end && (r_row >= h_last);

        b_margin = CW'(r_margin);
        b_left   = (CW'(r_min_col) > b_margin) ? CW'(r_min_col) - b_margin : '0;
        b_top    = (CW'(r_min_row) > b_margin) ? CW'(r_min_row) - b_margin : '0;
        b_right  = CW'(r_max_col) + b_margin;
        b_bottom = CW'(r_max_row) + b_margin;
        if (!r_any) begin
            b_left   = '0;
            b_top    = '0;
            b_right  = CW'(w_last);
            b_bottom = CW'(h_last);
        end
        if (b_left > CW'(w_last)) begin
            b_left = CW'(w_last);
        end
        if (b_top > CW'(h_last)) begin
            b_top = CW'(h_last);
        end
        if (b_right > CW'(w_last)) begin
            b_right = CW'(w_last);
        end
        if (b_bottom > CW'(h_last)) begin
            b_bottom = CW'(h_last);
        end
    end

    // Item sequencing
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (s_accept) n_state = ST_BUSY;
            ST_BUSY: if (eng_done) n_state = ST_PIX;
            ST_PIX: begin
                if (out_free) begin
                    n_state = frame_end ? ST_BOX : ST_IDLE;
                end
            end
            ST_BOX:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Counters and box tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_min_col <= '1;
            r_max_col <= '0;
            r_min_row <= '1;
            r_max_row <= '0;
            r_any     <= 1'b0;
        end else if (r_state == ST_PIX && out_free) begin
            if (opaque) begin
                if (r_col < r_min_col) r_min_col <= r_col;
                if (r_col > r_max_col) r_max_col <= r_col;
                if (r_row < r_min_row) r_min_row <= r_row;
                if (r_row > r_max_row) r_max_row <= r_row;
                r_any <= 1'b1;
            end
            if (!frame_end) begin
                if (line_end) begin
                    r_col <= '0;
                    r_row <= r_row + COORD_BITS'(1);
                end else begin
                    r_col <= r_col + COORD_BITS'(1);
                end
            end
        end else if (r_state == ST_BOX && out_free) begin
            r_col     <= '0;
            r_row     <= '0;
            r_min_col <= '1;
            r_max_col <= '0;
            r_min_row <= '1;
            r_max_row <= '0;
            r_any     <= 1'b0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_PIX || r_state == ST_BOX) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_PIX && out_free) begin
            r_out_data <= {7'd0, {(4 * BOX_BITS){1'b0}}, 1'b0, eng_pixel.alpha,
                           eng_pixel.blue, eng_pixel.green, eng_pixel.red};
            r_out_user <= KIND_PIXEL;
            r_out_last <= !frame_end;
        end else if (r_state == ST_BOX && out_free) begin
            r_out_data <= {7'd0, BOX_BITS'(b_bottom), BOX_BITS'(b_right), BOX_BITS'(b_top),
                           BOX_BITS'(b_left), r_any, 32'd0};
            r_out_user <= KIND_BOX;
            r_out_last <= 1'b1;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tlast  = r_out_last;

    // Checks
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state == ST_BUSY))
        else $error("accepted item did not start the engine");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_done |-> (r_state == ST_BUSY))
        else $error("engine finished outside an item");

    a_box_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_BOX) |-> m_axis_tlast)
        else $error("box report without last");

    a_pix_before_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BOX && r_out_valid) |-> !m_axis_tlast)
        else $error("frame-end pixel marked last ahead of its box report");

endmodule

`default_nettype wire
